/* rtl/lbm_eq_pkg.sv */
// shared types, register codes and fixed point helpers for the d2q9 equilibrium block
// no dependencies; used by every module under rtl
package lbm_eq_pkg;

  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned NUM_DIR = 8;  // moving directions, rest excluded
  localparam int unsigned NUM_OUT = 9;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [33:0] wide_t;

  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_LIN_COEF      = 3'd0,
    REG_QUAD_COEF     = 3'd1,
    REG_SPEED_SQ_COEF = 3'd2,
    REG_REST_WEIGHT   = 3'd3,
    REG_AXIS_WEIGHT   = 3'd4,
    REG_DIAG_WEIGHT   = 3'd5
  } reg_idx_e;

  localparam word_t LIN_COEF_RST      = 32'sd50331648;
  localparam word_t QUAD_COEF_RST     = 32'sd75497472;
  localparam word_t SPEED_SQ_COEF_RST = -32'sd25165824;
  localparam word_t REST_WEIGHT_RST   = 32'sd7456540;
  localparam word_t AXIS_WEIGHT_RST   = 32'sd1864135;
  localparam word_t DIAG_WEIGHT_RST   = 32'sd466034;

  typedef struct packed {
    word_t lin;
    word_t quad;
    word_t speed_sq;
    word_t w_rest;
    word_t w_axis;
    word_t w_diag;
  } coef_t;

  // front end result: weighted densities, |u|^2 and per direction terms
  typedef struct packed {
    word_t               wr_rest;
    word_t               wr_axis;
    word_t               wr_diag;
    word_t               usq;
    word_t [NUM_DIR-1:0] lp;  // lin_coef * p
    word_t [NUM_DIR-1:0] pp;  // p * p
  } front_t;

  // middle result: bracket terms per direction
  typedef struct packed {
    word_t               wr_rest;
    word_t               wr_axis;
    word_t               wr_diag;
    word_t               tn;
    word_t [NUM_DIR-1:0] br;
  } mid_t;

  function automatic word_t sat_wide(input wide_t v);
    if (v > 34'sd2147483647) begin
      return WORD_MAX;
    end else if (v < -34'sd2147483648) begin
      return WORD_MIN;
    end
    return v[WORD_W-1:0];
  endfunction

  // round to nearest (ties up), arithmetic shift, saturate
  function automatic word_t rnd_sat(input prod_t prod, input int unsigned frac);
    prod_t t;
    t = (prod + (64'sd1 <<< (frac - 1))) >>> frac;
    if (t > 64'sd2147483647) begin
      return WORD_MAX;
    end else if (t < -64'sd2147483648) begin
      return WORD_MIN;
    end
    return t[WORD_W-1:0];
  endfunction

endpackage

/* rtl/lbm_eq_front.sv */
// front end: direction projections, first products, rounding
// depends on lbm_eq_pkg
module lbm_eq_front #(
  parameter int unsigned FRAC_BITS = lbm_eq_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lbm_eq_pkg::word_t     density_i,
  input  lbm_eq_pkg::word_t     vel_x_i,
  input  lbm_eq_pkg::word_t     vel_y_i,
  input  lbm_eq_pkg::coef_t     coef_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lbm_eq_pkg::front_t    out_o
);
  import lbm_eq_pkg::*;

  logic [2:0] vld_q;
  logic [2:0] en;

  word_t p_d [NUM_DIR];
  word_t p_q [NUM_DIR];
  word_t rho_q, vx_q, vy_q;
  wide_t ex, ey;

  prod_t sqx_q, sqy_q;
  prod_t pp_raw_q [NUM_DIR];
  prod_t lp_raw_q [NUM_DIR];
  prod_t wrr_raw_q, wra_raw_q, wrd_raw_q;

  front_t res_d, res_q;

  assign en[2]      = !vld_q[2] || out_ready_i;
  assign en[1]      = !vld_q[1] || en[2];
  assign en[0]      = !vld_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  // projections, order: e n w s ne nw sw se
  always_comb begin
    ex = 34'(vel_x_i);
    ey = 34'(vel_y_i);
    p_d[0] = sat_wide(ex);
    p_d[1] = sat_wide(ey);
    p_d[2] = sat_wide(-ex);
    p_d[3] = sat_wide(-ey);
    p_d[4] = sat_wide(ex + ey);
    p_d[5] = sat_wide(ey - ex);
    p_d[6] = sat_wide(-ex - ey);
    p_d[7] = sat_wide(ex - ey);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rho_q <= density_i;
      vx_q  <= vel_x_i;
      vy_q  <= vel_y_i;
      for (int i = 0; i < NUM_DIR; i++) p_q[i] <= p_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sqx_q     <= 64'(vx_q) * 64'(vx_q);
      sqy_q     <= 64'(vy_q) * 64'(vy_q);
      wrr_raw_q <= 64'(coef_i.w_rest) * 64'(rho_q);
      wra_raw_q <= 64'(coef_i.w_axis) * 64'(rho_q);
      wrd_raw_q <= 64'(coef_i.w_diag) * 64'(rho_q);
      for (int i = 0; i < NUM_DIR; i++) begin
        pp_raw_q[i] <= 64'(p_q[i]) * 64'(p_q[i]);
        lp_raw_q[i] <= 64'(coef_i.lin) * 64'(p_q[i]);
      end
    end
  end

  always_comb begin
    res_d.wr_rest = rnd_sat(wrr_raw_q, FRAC_BITS);
    res_d.wr_axis = rnd_sat(wra_raw_q, FRAC_BITS);
    res_d.wr_diag = rnd_sat(wrd_raw_q, FRAC_BITS);
    res_d.usq     = sat_wide(34'(rnd_sat(sqx_q, FRAC_BITS)) + 34'(rnd_sat(sqy_q, FRAC_BITS)));
    for (int i = 0; i < NUM_DIR; i++) begin
      res_d.pp[i] = rnd_sat(pp_raw_q[i], FRAC_BITS);
      res_d.lp[i] = rnd_sat(lp_raw_q[i], FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) res_q <= res_d;
  end

  assign out_valid_o = vld_q[2];
  assign out_o       = res_q;

endmodule

/* rtl/lbm_eq_mid.sv */
// middle section: quadratic and speed terms, bracket sum per direction
// depends on lbm_eq_pkg
module lbm_eq_mid #(
  parameter int unsigned FRAC_BITS = lbm_eq_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lbm_eq_pkg::front_t    in_i,
  input  lbm_eq_pkg::word_t     quad_coef_i,
  input  lbm_eq_pkg::word_t     speed_sq_coef_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lbm_eq_pkg::mid_t      out_o
);
  import lbm_eq_pkg::*;

  localparam wide_t One = 34'sd1 <<< FRAC_BITS;

  logic [2:0] vld_q;
  logic [2:0] en;

  prod_t qpp_raw_q [NUM_DIR];
  prod_t tn_raw_q;
  word_t lp0_q [NUM_DIR];
  word_t wrr0_q, wra0_q, wrd0_q;

  word_t qpp_q [NUM_DIR];
  word_t tnm_q;
  word_t lp1_q [NUM_DIR];
  word_t wrr1_q, wra1_q, wrd1_q;

  word_t tn;
  mid_t  res_d, res_q;

  assign en[2]      = !vld_q[2] || out_ready_i;
  assign en[1]      = !vld_q[1] || en[2];
  assign en[0]      = !vld_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tn_raw_q <= 64'(in_i.usq) * 64'(speed_sq_coef_i);
      wrr0_q   <= in_i.wr_rest;
      wra0_q   <= in_i.wr_axis;
      wrd0_q   <= in_i.wr_diag;
      for (int i = 0; i < NUM_DIR; i++) begin
        qpp_raw_q[i] <= 64'($signed(in_i.pp[i])) * 64'(quad_coef_i);
        lp0_q[i]     <= in_i.lp[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      tnm_q  <= rnd_sat(tn_raw_q, FRAC_BITS);
      wrr1_q <= wrr0_q;
      wra1_q <= wra0_q;
      wrd1_q <= wrd0_q;
      for (int i = 0; i < NUM_DIR; i++) begin
        qpp_q[i] <= rnd_sat(qpp_raw_q[i], FRAC_BITS);
        lp1_q[i] <= lp0_q[i];
      end
    end
  end

  // tn saturates first, then one saturation of the three term sum
  always_comb begin
    tn = sat_wide(34'(tnm_q) + One);
    res_d.tn      = tn;
    res_d.wr_rest = wrr1_q;
    res_d.wr_axis = wra1_q;
    res_d.wr_diag = wrd1_q;
    for (int i = 0; i < NUM_DIR; i++) begin
      res_d.br[i] = sat_wide(34'(lp1_q[i]) + 34'(qpp_q[i]) + 34'(tn));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) res_q <= res_d;
  end

  assign out_valid_o = vld_q[2];
  assign out_o       = res_q;

endmodule

/* rtl/lbm_eq_back.sv */
// back end: weighted density times bracket, rounding, output register
// depends on lbm_eq_pkg
module lbm_eq_back #(
  parameter int unsigned FRAC_BITS = lbm_eq_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  lbm_eq_pkg::mid_t                              in_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output lbm_eq_pkg::word_t [lbm_eq_pkg::NUM_OUT-1:0]   dist_o
);
  import lbm_eq_pkg::*;

  logic [1:0] vld_q;
  logic [1:0] en;

  prod_t f_raw_q [NUM_OUT];
  word_t [NUM_OUT-1:0] dist_q;

  assign en[1]      = !vld_q[1] || out_ready_i;
  assign en[0]      = !vld_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
    end
  end

  // first four directions are axes, last four diagonals
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      f_raw_q[0] <= 64'(in_i.wr_rest) * 64'(in_i.tn);
      for (int i = 0; i < NUM_DIR; i++) begin
        if (i < 4) begin
          f_raw_q[i+1] <= 64'(in_i.wr_axis) * 64'($signed(in_i.br[i]));
        end else begin
          f_raw_q[i+1] <= 64'(in_i.wr_diag) * 64'($signed(in_i.br[i]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < NUM_OUT; i++) dist_q[i] <= rnd_sat(f_raw_q[i], FRAC_BITS);
    end
  end

  assign out_valid_o = vld_q[1];
  assign dist_o      = dist_q;

endmodule

/* rtl/lbm_d2q9_equilibrium.sv */
// top level of the d2q9 equilibrium block: register file, stream ports, pipeline
// depends on lbm_eq_pkg, lbm_eq_front, lbm_eq_mid, lbm_eq_back
//
// Takes one cell (density, vel_x, vel_y, signed fixed point with FRAC_BITS
// fraction bits) per clock while the output is not stalled and returns its
// nine equilibrium populations from a fully pipelined datapath of eight
// register stages: three in the front end (projections, first products,
// rounding), three in the middle (quadratic and speed products, rounding,
// bracket sums) and two at the back (weight products, rounding into the output
// register). Every stage holds its own request, so a stalled output only backs
// up the pipeline and bubbles are squeezed out. Coefficients and weights are
// written through the cfg port; the user must do so only while the block is
// idle, which it does not enforce. Reset loads the standard d2q9 values.
module lbm_d2q9_equilibrium #(
  parameter int unsigned FRAC_BITS = lbm_eq_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // density, vel_x, vel_y
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // dist_rest, dist_east, dist_north, dist_west, dist_south,
  // dist_north_east, dist_north_west, dist_south_west, dist_south_east
  output logic [287:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import lbm_eq_pkg::*;

  coef_t coef_q;

  logic   fr_valid, fr_ready;
  front_t fr_data;
  logic   md_valid, md_ready;
  mid_t   md_data;
  word_t [NUM_OUT-1:0] pop_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.lin      <= LIN_COEF_RST;
      coef_q.quad     <= QUAD_COEF_RST;
      coef_q.speed_sq <= SPEED_SQ_COEF_RST;
      coef_q.w_rest   <= REST_WEIGHT_RST;
      coef_q.w_axis   <= AXIS_WEIGHT_RST;
      coef_q.w_diag   <= DIAG_WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_LIN_COEF:      coef_q.lin      <= cfg_data_i;
        REG_QUAD_COEF:     coef_q.quad     <= cfg_data_i;
        REG_SPEED_SQ_COEF: coef_q.speed_sq <= cfg_data_i;
        REG_REST_WEIGHT:   coef_q.w_rest   <= cfg_data_i;
        REG_AXIS_WEIGHT:   coef_q.w_axis   <= cfg_data_i;
        REG_DIAG_WEIGHT:   coef_q.w_diag   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lbm_eq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .density_i   (s_axis_tdata[31:0]),
    .vel_x_i     (s_axis_tdata[63:32]),
    .vel_y_i     (s_axis_tdata[95:64]),
    .coef_i      (coef_q),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_o       (fr_data)
  );

  lbm_eq_mid #(.FRAC_BITS(FRAC_BITS)) u_mid (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (fr_valid),
    .in_ready_o      (fr_ready),
    .in_i            (fr_data),
    .quad_coef_i     (coef_q.quad),
    .speed_sq_coef_i (coef_q.speed_sq),
    .out_valid_o     (md_valid),
    .out_ready_i     (md_ready),
    .out_o           (md_data)
  );

  lbm_eq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (md_valid),
    .in_ready_o  (md_ready),
    .in_i        (md_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .dist_o      (pop_vec)
  );

  assign m_axis_tdata = pop_vec;

endmodule

/* dv/lbm_eq_checker.sv */
// scoreboard for the d2q9 equilibrium block: watches the cell, result and config ports,
// predicts the nine populations per cell and compares them in order
// depends on lbm_eq_pkg for word type, register indexes and reset values
module lbm_eq_checker #(
  parameter int unsigned FRAC_BITS = lbm_eq_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [95:0]  s_tdata_i,   // density, vel_x, vel_y
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  // dist_rest, dist_east, dist_north, dist_west, dist_south,
  // dist_north_east, dist_north_west, dist_south_west, dist_south_east
  input  logic [287:0] m_tdata_i,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  output int           fail_cnt_o,
  output int           pending_o,
  output int           checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lbm_eq_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef word_t [NUM_OUT-1:0] pop_vec_t;

  word_t lin_c, quad_c, ssq_c, w_rest, w_axis, w_diag;
  pop_vec_t awaited_pops [$];
  int fail_cnt;
  int checked_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = awaited_pops.size();
  assign checked_o  = checked_cnt;

  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // fixed point product, rounded half up, saturated
  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b + (longint'(1) <<< (FRAC_BITS - 1));
    return sat_word(p >>> FRAC_BITS);
  endfunction

  function automatic longint dir_pop(input longint wrho, input longint proj,
                                     input longint tn);
    longint br;
    br = sat_word(qmul(lin_c, proj) + qmul(quad_c, qmul(proj, proj)) + tn);
    return qmul(wrho, br);
  endfunction

  function automatic pop_vec_t equilibrium_pops(input word_t rho_w, input word_t vx_w,
                                                input word_t vy_w);
    longint rho, vx, vy, usq, tn, wa, wd;
    pop_vec_t pops;
    rho = rho_w;
    vx  = vx_w;
    vy  = vy_w;
    usq = sat_word(qmul(vx, vx) + qmul(vy, vy));
    tn  = sat_word(qmul(usq, ssq_c) + (longint'(1) <<< FRAC_BITS));
    pops[0] = word_t'(qmul(qmul(w_rest, rho), tn));
    wa = qmul(w_axis, rho);
    pops[1] = word_t'(dir_pop(wa, vx, tn));
    pops[2] = word_t'(dir_pop(wa, vy, tn));
    pops[3] = word_t'(dir_pop(wa, sat_word(-vx), tn));
    pops[4] = word_t'(dir_pop(wa, sat_word(-vy), tn));
    wd = qmul(w_diag, rho);
    pops[5] = word_t'(dir_pop(wd, sat_word(vx + vy), tn));
    pops[6] = word_t'(dir_pop(wd, sat_word(-vx + vy), tn));
    pops[7] = word_t'(dir_pop(wd, sat_word(-vx - vy), tn));
    pops[8] = word_t'(dir_pop(wd, sat_word(vx - vy), tn));
    return pops;
  endfunction

  function automatic string pop_name(input int k);
    case (k)
      0: return "dist_rest";
      1: return "dist_east";
      2: return "dist_north";
      3: return "dist_west";
      4: return "dist_south";
      5: return "dist_north_east";
      6: return "dist_north_west";
      7: return "dist_south_west";
      default: return "dist_south_east";
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pop_vec_t want;
    pop_vec_t got;
    if (!rst_ni) begin
      lin_c  <= LIN_COEF_RST;
      quad_c <= QUAD_COEF_RST;
      ssq_c  <= SPEED_SQ_COEF_RST;
      w_rest <= REST_WEIGHT_RST;
      w_axis <= AXIS_WEIGHT_RST;
      w_diag <= DIAG_WEIGHT_RST;
      awaited_pops.delete();
      fail_cnt    = 0;
      checked_cnt = 0;
    end else begin
      // writes must come only while idle, unchecked; no request sees a half-updated set
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LIN_COEF:      lin_c  <= cfg_data_i;
          REG_QUAD_COEF:     quad_c <= cfg_data_i;
          REG_SPEED_SQ_COEF: ssq_c  <= cfg_data_i;
          REG_REST_WEIGHT:   w_rest <= cfg_data_i;
          REG_AXIS_WEIGHT:   w_axis <= cfg_data_i;
          REG_DIAG_WEIGHT:   w_diag <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        awaited_pops.push_back(equilibrium_pops(s_tdata_i[31:0], s_tdata_i[63:32],
                                                s_tdata_i[95:64]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (awaited_pops.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("%0t: result with no cell pending, tdata %h", $realtime, m_tdata_i);
          end
        end else begin
          want = awaited_pops.pop_front();
          checked_cnt++;
          for (int k = 0; k < NUM_OUT; k++) begin
            if (got[k] !== want[k]) begin
              fail_cnt++;
              if (fail_cnt <= MAX_REPORTS) begin
                $display("%0t: result %0d %s: want %h got %h", $realtime, checked_cnt,
                         pop_name(k), want[k], got[k]);
              end
            end
          end
        end
      end
    end
  end

endmodule

/* dv/lbm_d2q9_equilibrium_tb.sv */
// top of the d2q9 equilibrium testbench: clock, reset, cell stimulus, output stalls
// and config phases; checking is done by lbm_eq_checker, depends on lbm_eq_pkg
module lbm_d2q9_equilibrium_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbm_eq_pkg::*;

  localparam int unsigned FRAC_BITS = FRAC_BITS_DEF;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int TAIL_CYCLES = 16;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam word_t ONE = 32'sh0100_0000;
  localparam word_t HALF = 32'sh0080_0000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [287:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int cells_sent;
  int settings_used;
  int cycle_cnt;
  bit steady;

  lbm_d2q9_equilibrium #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  lbm_eq_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_i(s_axis_tready),
    .s_tdata_i (s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_i (m_axis_tdata),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending_cnt),
    .checked_o (checked_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("run stopped after %0d cycles, %0d results still pending",
               cycle_cnt, pending_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(15, 40);
  endfunction

  function automatic word_t corner_word();
    case ($urandom_range(0, 6))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return 32'sd1;
      4: return -32'sd1;
      5: return ONE;
      default: return -ONE;
    endcase
  endfunction

  // typical flow speeds, well under the lattice sound speed
  function automatic word_t flow_vel();
    return word_t'(int'($urandom_range(0, 13421772)) - 6710886);
  endfunction

  function automatic word_t rand_coef();
    case ($urandom_range(0, 2))
      0: return word_t'($urandom);
      1: return word_t'(int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
      default: return word_t'(int'($urandom_range(0, 32'h0200_0000)) - ONE);
    endcase
  endfunction

  // receiver: random stalls on the result side
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        m_axis_tready = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = idle_len();
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_cell(input word_t rho, input word_t vx, input word_t vy);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {vy, vx, rho};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    cells_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input word_t val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
  endtask

  // also pokes the unused indexes, which must leave every register alone
  task automatic set_coefs(input word_t lin, input word_t quad, input word_t ssq,
                           input word_t wr, input word_t wa, input word_t wd);
    drain();
    cfg_write(REG_LIN_COEF, lin);
    cfg_write(REG_SPARE_LO, word_t'($urandom));
    cfg_write(REG_QUAD_COEF, quad);
    cfg_write(REG_SPEED_SQ_COEF, ssq);
    cfg_write(REG_REST_WEIGHT, wr);
    cfg_write(REG_AXIS_WEIGHT, wa);
    cfg_write(REG_DIAG_WEIGHT, wd);
    cfg_write(REG_SPARE_HI, word_t'($urandom));
    cfg_we_i = 1'b0;
    settings_used++;
  endtask

  task automatic run_cells(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_cell(word_t'($urandom_range(32'h0080_0000, 32'h0200_0000)), flow_vel(),
                  flow_vel());
      end else if (r < 85) begin
        send_cell(word_t'($urandom), word_t'($urandom), word_t'($urandom));
      end else begin
        send_cell(corner_word(), corner_word(), corner_word());
      end
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_LIN_COEF;
    cfg_data_i    = '0;
    cells_sent    = 0;
    settings_used = 1;
    steady        = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed cells at the reset coefficients
    send_cell('0, '0, '0);
    send_cell(ONE, '0, '0);
    send_cell(ONE, 32'sd1677722, -32'sd838861);
    send_cell(WORD_MAX, WORD_MAX, WORD_MIN);
    send_cell(WORD_MAX, WORD_MIN, WORD_MIN);
    send_cell(WORD_MIN, WORD_MAX, WORD_MAX);
    send_cell(WORD_MIN, WORD_MIN, WORD_MAX);
    send_cell(-ONE, 32'sd5033165, 32'sd3355443);
    // the axis weight times half density lands exactly on a rounding tie
    send_cell(HALF, '0, '0);
    send_cell(-HALF, '0, '0);
    send_cell(ONE, 32'sd1, -32'sd1);
    send_cell(-32'sd1, -32'sd1, -32'sd1);
    send_cell(ONE, ONE, ONE);
    send_cell(32'sh4000_0000, 32'sh1000_0000, -32'sh1000_0000);
    send_cell(ONE, WORD_MIN, '0);
    send_cell(ONE, '0, WORD_MIN);

    steady = 1'b1;
    run_cells(100);
    steady = 1'b0;
    run_cells(300);

    set_coefs(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    run_cells(120);
    set_coefs(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    run_cells(120);
    set_coefs('0, '0, '0, '0, '0, '0);
    run_cells(80);
    for (int p = 0; p < 4; p++) begin
      set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                rand_coef());
      steady = (p == 2);
      run_cells(150);
    end
    steady = 1'b0;
    set_coefs(LIN_COEF_RST, QUAD_COEF_RST, SPEED_SQ_COEF_RST, REST_WEIGHT_RST,
              AXIS_WEIGHT_RST, DIAG_WEIGHT_RST);
    run_cells(200);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);

    $display("%0d cells over %0d coefficient sets, %0d population sets compared",
             cells_sent, settings_used, checked_cnt);
    if (pending_cnt != 0) begin
      $display("%0d results never came out", pending_cnt);
    end
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
